// ===== sv/sre_pkg.sv =====
// Shared types, constants and helper functions for the RGB Sobel edge magnitude block.
// Used by sre_chan, the top level and the testbench; depends on nothing.
`default_nettype none

package sre_pkg;

  // Line store geometry and frame limits.
  localparam int MAX_WIDTH    = 1024;
  localparam int COL_W        = $clog2(MAX_WIDTH);
  localparam int HEIGHT_LIMIT = 4096;
  localparam int ROW_W        = $clog2(HEIGHT_LIMIT);

  // Register and payload widths.
  localparam int WIDTH_W  = 11;
  localparam int HEIGHT_W = 13;
  localparam int CFG_W    = 13;
  localparam int CHAN_W   = 8;
  localparam int PIX_W    = 3 * CHAN_W;
  localparam int LINE_W   = 2 * PIX_W;

  // Reset values of the configuration registers.
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(1024);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(1024);

  // Smallest frame the window can work on.
  localparam int MIN_DIM = 3;

  // Square root: eight result bits, two per cycle.
  localparam int ROOT_CYCLES = 4;
  localparam int ROOT_CNT_W  = $clog2(ROOT_CYCLES);
  localparam logic [CHAN_W-1:0] MAG_SAT = {CHAN_W{1'b1}};

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_IMAGE_WIDTH  = 1'b0,
    REG_IMAGE_HEIGHT = 1'b1
  } sre_reg_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_GRAD,
    S_SQR,
    S_ROOT,
    S_DONE
  } sre_state_e;

  // Controls from the sequencer to the channel units.
  typedef struct packed {
    logic grad_en;
    logic sqr_en;
    logic root_en;
    logic root_first;
  } sre_ctrl_t;

  // Partial remainder and partial root of the digit-by-digit square root.
  typedef struct packed {
    logic [10:0]       rem;
    logic [CHAN_W-1:0] root;
  } sre_acc_t;

  // One radix-4 step of the square root: bring down two bits, try root*4+1.
  function automatic sre_acc_t sqrt_step(sre_acc_t acc, logic [1:0] pair);
    logic [10:0] r;
    logic [10:0] t;
    sre_acc_t    o;
    r = {acc.rem[8:0], pair};
    t = {1'b0, acc.root, 2'b01};
    if (r >= t) begin
      o.rem  = r - t;
      o.root = {acc.root[CHAN_W-2:0], 1'b1};
    end else begin
      o.rem  = r;
      o.root = {acc.root[CHAN_W-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== sv/sre_pix_if.sv =====
// Pixel input channel: valid/ready handshake carrying one RGB pixel.
// Standalone interface, no dependencies.
`default_nettype none

interface sre_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source(output valid, output red, output green, output blue, input ready);
  modport sink(input valid, input red, input green, input blue, output ready);
endinterface

`default_nettype wire

// ===== sv/sre_mag_if.sv =====
// Result channel: valid/ready handshake carrying three magnitudes and a frame end flag.
// Standalone interface, no dependencies.
`default_nettype none

interface sre_mag_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_magnitude;
  logic [7:0] green_magnitude;
  logic [7:0] blue_magnitude;
  logic       frame_end;

  modport source(output valid, output red_magnitude, output green_magnitude,
                 output blue_magnitude, output frame_end, input ready);
  modport sink(input valid, input red_magnitude, input green_magnitude,
               input blue_magnitude, input frame_end, output ready);
endinterface

`default_nettype wire

// ===== sv/sre_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
`default_nettype none

module sre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/sre_chan.sv =====
// One color channel: Sobel gradients, sum of squares and a saturating square root.
// Depends on sre_pkg; steered by the sequencer in the top level.
`default_nettype none

module sre_chan (
  input  logic                                 clk_i,
  input  sre_pkg::sre_ctrl_t                   ctrl_i,
  input  logic [8:0][sre_pkg::CHAN_W-1:0]      win_i,
  output logic [sre_pkg::CHAN_W-1:0]           mag_o
);
  import sre_pkg::*;

  logic [9:0]         pos_x, neg_x, pos_y, neg_y;
  logic signed [10:0] gx_d, gy_d;
  logic signed [10:0] gx_q, gy_q;
  logic signed [21:0] sqx, sqy;
  logic [20:0]        sum_q;
  logic [15:0]        rad_src, rad_q;
  sre_acc_t           acc_src, acc_mid, acc_d, acc_q;

  // Weighted column and row sums of the window, then their differences.
  always_comb begin
    pos_x = {2'b00, win_i[2]} + {1'b0, win_i[5], 1'b0} + {2'b00, win_i[8]};
    neg_x = {2'b00, win_i[0]} + {1'b0, win_i[3], 1'b0} + {2'b00, win_i[6]};
    pos_y = {2'b00, win_i[6]} + {1'b0, win_i[7], 1'b0} + {2'b00, win_i[8]};
    neg_y = {2'b00, win_i[0]} + {1'b0, win_i[1], 1'b0} + {2'b00, win_i[2]};
    gx_d  = $signed({1'b0, pos_x}) - $signed({1'b0, neg_x});
    gy_d  = $signed({1'b0, pos_y}) - $signed({1'b0, neg_y});
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.grad_en) begin
      gx_q <= gx_d;
      gy_q <= gy_d;
    end
  end

  // Squares are non-negative and below 2^20, so the sum fits in 21 bits.
  assign sqx = 22'(gx_q) * 22'(gx_q);
  assign sqy = 22'(gy_q) * 22'(gy_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sqr_en) begin
      sum_q <= sqx[20:0] + sqy[20:0];
    end
  end

  // Two root digits per cycle; the first cycle starts from the fresh sum.
  always_comb begin
    rad_src = ctrl_i.root_first ? sum_q[15:0] : rad_q;
    acc_src = ctrl_i.root_first ? '0 : acc_q;
    acc_mid = sqrt_step(acc_src, rad_src[15:14]);
    acc_d   = sqrt_step(acc_mid, rad_src[13:12]);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.root_en) begin
      rad_q <= {rad_src[11:0], 4'b0000};
      acc_q <= acc_d;
    end
  end

  // Anything at or above 2^16 has a root of at least 256 and saturates.
  assign mag_o = (sum_q[20:16] != 5'd0) ? MAG_SAT : acc_q.root;

endmodule

`default_nettype wire

// ===== sv/sobel_rgb_edge_magnitude.sv =====
// Top level of the RGB Sobel edge magnitude block: sequencer, counters, window and line stores.
// Depends on sre_pkg, sre_pix_if, sre_mag_if, sre_ram and sre_chan.
//
// Usage: RGB pixels enter on pix_i in raster order, image_width pixels per row and
// image_height rows per frame (both clamped to 3..1024 and 3..4096). For every interior
// pixel one request leaves on mag_o with the floor of the Sobel gradient magnitude of each
// channel, saturated at 255; frame_end marks the last request of a frame. The result for
// the pixel at (x-1, y-1) is formed when the pixel at (x, y) arrives.
// Both line stores share one 48-bit RAM of 1024 entries: the column is read when a pixel is
// taken and written back in the next cycle, after which a pixel that gives no result is done.
// A pixel that gives a result passes through read, window update, gradients, squares, the
// square root steps of two digits each, and the hand-off into the output register.
// The output register holds a result while the receiver stalls; the block keeps taking
// pixels, and only stops at the hand-off of the next result until the old one is taken.
// Reset clears the window, the counters and the output valid and restores the register
// defaults; the line stores need no clearing, since a frame only reads what it wrote.
// A register write over cfg_we_i restarts the frame at the next pixel.
`default_nettype none

module sobel_rgb_edge_magnitude (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  sre_pix_if.sink                     pix_i,
  sre_mag_if.source                   mag_o,
  input  logic                        cfg_we_i,
  input  sre_pkg::sre_reg_e           cfg_idx_i,
  input  logic [sre_pkg::CFG_W-1:0]   cfg_data_i
);
  import sre_pkg::*;

  sre_state_e                 state_q, state_d;
  logic [WIDTH_W-1:0]         width_q;
  logic [HEIGHT_W-1:0]        height_q;
  logic [COL_W-1:0]           col_q, wcol_q, w_m1;
  logic [ROW_W-1:0]           row_q, h_m1;
  logic [31:0]                w_lim, h_lim;
  logic [PIX_W-1:0]           px_q;
  logic                       emit_q, last_q;
  logic [8:0][PIX_W-1:0]      win_q;
  logic [ROOT_CNT_W-1:0]      root_cnt_q;
  logic                       accept, pix_ready, ram_re, ram_we, load_out;
  logic [LINE_W-1:0]          ram_rdata;
  sre_ctrl_t                  ctrl;
  logic [2:0][8:0][CHAN_W-1:0] chan_win;
  logic [2:0][CHAN_W-1:0]     chan_mag;
  logic                       out_valid_q;
  logic [2:0][CHAN_W-1:0]     out_mag_q;
  logic                       out_last_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_data_i[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_data_i[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Frame geometry in use, clamped, as last column and last row.
  always_comb begin
    w_lim = 32'(width_q);
    if (w_lim < MIN_DIM) w_lim = MIN_DIM;
    if (w_lim > MAX_WIDTH) w_lim = MAX_WIDTH;
    h_lim = 32'(height_q);
    if (h_lim < MIN_DIM) h_lim = MIN_DIM;
    if (h_lim > HEIGHT_LIMIT) h_lim = HEIGHT_LIMIT;
    w_m1 = COL_W'(w_lim - 32'd1);
    h_m1 = ROW_W'(h_lim - 32'd1);
  end

  assign accept = pix_i.valid && pix_ready;

  // Position counters; a register write restarts the frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_we_i) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (col_q == w_m1) begin
        col_q <= '0;
        row_q <= (row_q == h_m1) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_q + COL_W'(1);
      end
    end
  end

  // Capture the request and its position flags while the line stores are read.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q   <= {pix_i.blue, pix_i.green, pix_i.red};
      wcol_q <= col_q;
      emit_q <= (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2));
      last_q <= (col_q == w_m1) && (row_q == h_m1);
    end
  end

  // Both line stores in one RAM: older row in the upper half, newer row in the lower.
  sre_ram #(
    .WIDTH(LINE_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wcol_q),
    .wdata_i ({ram_rdata[PIX_W-1:0], px_q}),
    .re_i    (ram_re),
    .raddr_i (col_q),
    .rdata_o (ram_rdata)
  );

  // Window shifts left by one column once the line store data is back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (state_q == S_READ) begin
      win_q[0] <= win_q[1];
      win_q[1] <= win_q[2];
      win_q[2] <= ram_rdata[LINE_W-1:PIX_W];
      win_q[3] <= win_q[4];
      win_q[4] <= win_q[5];
      win_q[5] <= ram_rdata[PIX_W-1:0];
      win_q[6] <= win_q[7];
      win_q[7] <= win_q[8];
      win_q[8] <= px_q;
    end
  end

  // Sequencer state register and root cycle counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      root_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      root_cnt_q <= (state_q == S_ROOT) ? root_cnt_q + ROOT_CNT_W'(1) : '0;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (pix_i.valid) state_d = S_READ;
      S_READ: state_d = emit_q ? S_GRAD : S_IDLE;
      S_GRAD: state_d = S_SQR;
      S_SQR:  state_d = S_ROOT;
      S_ROOT: if (root_cnt_q == ROOT_CNT_W'(ROOT_CYCLES - 1)) state_d = S_DONE;
      S_DONE: if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    pix_ready = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    load_out  = 1'b0;
    ctrl      = '0;
    case (state_q)
      S_IDLE: begin
        pix_ready = 1'b1;
        ram_re    = pix_i.valid;
      end
      S_READ: ram_we = 1'b1;
      S_GRAD: ctrl.grad_en = 1'b1;
      S_SQR:  ctrl.sqr_en = 1'b1;
      S_ROOT: begin
        ctrl.root_en    = 1'b1;
        ctrl.root_first = (root_cnt_q == '0);
      end
      S_DONE: load_out = !out_valid_q || mag_o.ready;
      default: ;
    endcase
  end

  assign pix_i.ready = pix_ready;

  // Split the window into channels and run one gradient unit per channel.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int k = 0; k < 9; k++) begin
        chan_win[c][k] = win_q[k][CHAN_W*c +: CHAN_W];
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_chan
    sre_chan u_chan (
      .clk_i (clk_i),
      .ctrl_i(ctrl),
      .win_i (chan_win[c]),
      .mag_o (chan_mag[c])
    );
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (mag_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_mag_q  <= chan_mag;
      out_last_q <= last_q;
    end
  end

  assign mag_o.valid           = out_valid_q;
  assign mag_o.red_magnitude   = out_mag_q[0];
  assign mag_o.green_magnitude = out_mag_q[1];
  assign mag_o.blue_magnitude  = out_mag_q[2];
  assign mag_o.frame_end       = out_last_q;

  // A new result only appears out of the hand-off state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_DONE)
    else $error("result raised outside hand-off");

  // The line store is never read and written in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !ram_re)
    else $error("line store read and write overlap");

  // A taken pixel is always followed by its line store cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_READ)
    else $error("pixel request not followed by line store update");

  // A pending result is never overwritten before it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || mag_o.ready))
    else $error("pending result overwritten");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the RGB Sobel edge magnitude block.
// Depends on sre_pkg, sre_pix_if, sre_mag_if and the sobel_rgb_edge_magnitude top level;
// a built-in line-store and window predictor checks every result request in order.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sre_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 11;
  localparam int SETTLE_CYCLES = 12;
  localparam int END_CYCLES    = 20;
  localparam int HOLD_CYCLES   = 400;
  localparam int RANDOM_PIXELS = 1600;
  localparam int WIDE_PIXELS   = 40;
  localparam int CYCLE_LIMIT   = 2000000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pix_t;

  typedef struct packed {
    logic [7:0] red_magnitude;
    logic [7:0] green_magnitude;
    logic [7:0] blue_magnitude;
    logic       frame_end;
  } mag_t;

  typedef enum logic [0:0] {ROW_PIXEL, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    sre_reg_e          idx;
    logic [CFG_W-1:0]  data;
    pix_t              px;
    logic              checked;
    mag_t              want;
  } dir_row_t;

  typedef enum logic [1:0] {TEX_NOISE, TEX_BINARY, TEX_SMOOTH} texture_e;

  logic clk_i;
  logic rst_ni;
  logic cfg_we;
  sre_reg_e cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  sre_pix_if pix_bus ();
  sre_mag_if mag_bus ();

  sobel_rgb_edge_magnitude u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix_i      (pix_bus.sink),
    .mag_o      (mag_bus.source),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Predictor state: registers, two line stores, window and raster position.
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  logic [PIX_W-1:0]    line_older [MAX_WIDTH];
  logic [PIX_W-1:0]    line_newer [MAX_WIDTH];
  logic [PIX_W-1:0]    win [9];
  int unsigned         col_pos;
  int unsigned         row_pos;

  mag_t        pending_mags [$];
  mag_t        head_mag;
  int unsigned pixels_sent;
  int unsigned mags_checked;
  int unsigned frames_seen;
  int unsigned reg_writes;
  int unsigned fail_count;
  int unsigned cycle_count;
  bit          src_quiet;
  bit          hold_requested;
  bit          hold_served;

  dir_row_t dir_rows [23];

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Row length and frame height as the block clamps them.
  function automatic int unsigned row_len();
    int unsigned w;
    w = width_reg;
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned frame_rows();
    int unsigned h;
    h = height_reg;
    if (h < MIN_DIM) h = MIN_DIM;
    if (h > HEIGHT_LIMIT) h = HEIGHT_LIMIT;
    return h;
  endfunction

  function automatic int px_chan(logic [PIX_W-1:0] p, int c);
    return int'(p[8*c +: 8]);
  endfunction

  // Sobel magnitude of one channel of the current window, floor of the root, saturated.
  function automatic logic [7:0] chan_mag(int c);
    int          gx;
    int          gy;
    int          sum;
    int          trial;
    int          b;
    logic [8:0]  root;
    gx = (px_chan(win[2], c) + 2 * px_chan(win[5], c) + px_chan(win[8], c))
       - (px_chan(win[0], c) + 2 * px_chan(win[3], c) + px_chan(win[6], c));
    gy = (px_chan(win[6], c) + 2 * px_chan(win[7], c) + px_chan(win[8], c))
       - (px_chan(win[0], c) + 2 * px_chan(win[1], c) + px_chan(win[2], c));
    sum = gx * gx + gy * gy;
    if (sum >= 65536) return 8'hFF;
    root = '0;
    for (b = 7; b >= 0; b--) begin
      trial = int'(root) | (1 << b);
      if (trial * trial <= sum) root = 9'(trial);
    end
    return root[7:0];
  endfunction

  // Take one pixel into the predictor; returns 1 with the result when the pixel gives one.
  function automatic bit predict_magnitudes(input pix_t px, output mag_t res);
    int unsigned      w;
    int unsigned      h;
    int unsigned      c;
    int unsigned      r;
    int unsigned      k;
    logic [PIX_W-1:0] packed_px;
    bit               produced;
    w = row_len();
    h = frame_rows();
    c = col_pos;
    r = row_pos;
    if (c >= w) c = w - 1;
    if (r >= h) r = h - 1;
    packed_px = {px.blue, px.green, px.red};
    for (k = 0; k < 3; k++) begin
      win[3*k]     = win[3*k + 1];
      win[3*k + 1] = win[3*k + 2];
    end
    win[2] = line_older[c];
    win[5] = line_newer[c];
    win[8] = packed_px;
    line_older[c] = line_newer[c];
    line_newer[c] = packed_px;
    produced = 1'b0;
    res = '0;
    if (c >= 2 && r >= 2) begin
      res.red_magnitude   = chan_mag(0);
      res.green_magnitude = chan_mag(1);
      res.blue_magnitude  = chan_mag(2);
      res.frame_end       = (c == w - 1) && (r == h - 1);
      produced = 1'b1;
    end
    // Advance the raster position, wrapping at the end of the frame.
    if (c + 1 >= w) begin
      c = 0;
      r = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      c++;
    end
    col_pos = c;
    row_pos = r;
    return produced;
  endfunction

  function automatic void reset_predictor();
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    foreach (line_older[i]) begin
      line_older[i] = '0;
      line_newer[i] = '0;
    end
    foreach (win[i]) win[i] = '0;
    col_pos = 0;
    row_pos = 0;
  endfunction

  // Pixel source: random gap, then hold the request until the block takes it.
  function automatic int pick_gap();
    int roll;
    if (src_quiet) return 0;
    roll = $urandom_range(0, 19);
    if (roll < 13) return 0;
    if (roll < 19) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_pixel(input pix_t px, input bit use_typed, input mag_t typed_mag);
    int   gap;
    mag_t res;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk_i);
      pix_bus.valid <= 1'b0;
    end
    @(negedge clk_i);
    pix_bus.valid <= 1'b1;
    pix_bus.red   <= px.red;
    pix_bus.green <= px.green;
    pix_bus.blue  <= px.blue;
    do @(posedge clk_i); while (!pix_bus.ready);
    if (predict_magnitudes(px, res)) begin
      pending_mags.insert(pending_mags.size(), use_typed ? typed_mag : res);
    end
    pixels_sent++;
    if (pixels_sent % 150 == 0) src_quiet = ($urandom_range(0, 2) == 0);
  endtask

  // Drop the request line and wait until every expected result has been taken.
  task automatic wait_for_results();
    @(negedge clk_i);
    pix_bus.valid <= 1'b0;
    while (pending_mags.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Register write, only once the block has gone idle.
  task automatic write_reg(input sre_reg_e idx, input logic [CFG_W-1:0] val);
    wait_for_results();
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_IMAGE_WIDTH) width_reg = val[WIDTH_W-1:0];
    else height_reg = val[HEIGHT_W-1:0];
    col_pos = 0;
    row_pos = 0;
    reg_writes++;
  endtask

  function automatic logic [7:0] texel(texture_e tex, logic [7:0] base);
    case (tex)
      TEX_NOISE:  return 8'($urandom_range(0, 255));
      TEX_BINARY: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      default:    return base + 8'($urandom_range(0, 12));
    endcase
  endfunction

  function automatic pix_t random_pixel(texture_e tex, logic [7:0] base);
    pix_t p;
    p.red   = texel(tex, base);
    p.green = texel(tex, base);
    p.blue  = texel(tex, base);
    return p;
  endfunction

  function automatic dir_row_t pixel_row(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    dir_row_t row;
    row = '0;
    row.kind = ROW_PIXEL;
    row.px   = '{r, g, b};
    return row;
  endfunction

  function automatic dir_row_t checked_row(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                           mag_t want);
    dir_row_t row;
    row = pixel_row(r, g, b);
    row.checked = 1'b1;
    row.want    = want;
    return row;
  endfunction

  function automatic dir_row_t write_row(sre_reg_e idx, logic [CFG_W-1:0] val);
    dir_row_t row;
    row = '0;
    row.kind = ROW_WRITE;
    row.idx  = idx;
    row.data = val;
    return row;
  endfunction

  // Random frames: mostly whole frames of small sizes, some cut short by a register write.
  task automatic run_random_frames();
    int unsigned start_count;
    int unsigned w_val;
    int unsigned h_val;
    int unsigned per_frame;
    int unsigned frames;
    int unsigned cut;
    int unsigned phase;
    int unsigned sel;
    texture_e    tex;
    logic [7:0]  base;
    start_count = pixels_sent;
    phase = 0;
    while (pixels_sent - start_count < RANDOM_PIXELS) begin
      case ($urandom_range(0, 7))
        0:       w_val = $urandom_range(0, 2);
        1:       w_val = $urandom_range(13, 40);
        default: w_val = $urandom_range(3, 12);
      endcase
      case ($urandom_range(0, 7))
        0:       h_val = $urandom_range(0, 2);
        1:       h_val = $urandom_range(7, 12);
        default: h_val = $urandom_range(3, 6);
      endcase
      sel = $urandom_range(0, 3);
      if (sel != 1) write_reg(REG_IMAGE_WIDTH, CFG_W'(w_val));
      if (sel != 2) write_reg(REG_IMAGE_HEIGHT, CFG_W'(h_val));
      per_frame = row_len() * frame_rows();
      // The hold-off phase runs several frames, so a second result always backs up.
      frames = (phase == 1) ? 3 : $urandom_range(1, 3);
      tex = texture_e'($urandom_range(0, 2));
      base = 8'($urandom_range(0, 240));
      // Once, stall the result side for a long stretch while pixels keep coming.
      if (phase == 1) hold_requested = 1'b1;
      for (int f = 0; f < frames; f++) begin
        for (int i = 0; i < per_frame; i++) begin
          // Once, the source pauses mid-frame until all results are back.
          if (phase == 3 && f == 0 && i == per_frame / 2) wait_for_results();
          send_pixel(random_pixel(tex, base), 1'b0, '0);
        end
      end
      if ($urandom_range(0, 3) == 0) begin
        cut = $urandom_range(1, per_frame - 1);
        repeat (cut) send_pixel(random_pixel(tex, base), 1'b0, '0);
      end
      phase++;
    end
  endtask

  // Result sink: random stalls, quiet stretches, and one long hold-off on request.
  initial begin : result_sink
    int stall;
    int quiet_left;
    bit quiet;
    mag_bus.ready = 1'b0;
    stall = 0;
    quiet = 1'b0;
    quiet_left = 300;
    forever begin
      @(negedge clk_i);
      if (hold_requested && !hold_served) begin
        hold_served = 1'b1;
        stall = HOLD_CYCLES;
      end
      if (quiet_left == 0) begin
        quiet = ($urandom_range(0, 2) == 0);
        quiet_left = 300;
      end
      quiet_left--;
      if (stall == 0 && !quiet && $urandom_range(0, 4) == 0) begin
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      end
      if (stall > 0) begin
        mag_bus.ready <= 1'b0;
        stall--;
      end else begin
        mag_bus.ready <= 1'b1;
      end
    end
  end

  // Result checker: every taken result against the oldest expectation.
  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && mag_bus.valid && mag_bus.ready) begin
      if (pending_mags.size() == 0) begin
        $error("result with nothing expected: %0d %0d %0d frame_end=%0b",
               mag_bus.red_magnitude, mag_bus.green_magnitude, mag_bus.blue_magnitude,
               mag_bus.frame_end);
        fail_count++;
      end else begin
        head_mag = pending_mags.pop_front();
        compare_field("red_magnitude", head_mag.red_magnitude, mag_bus.red_magnitude);
        compare_field("green_magnitude", head_mag.green_magnitude, mag_bus.green_magnitude);
        compare_field("blue_magnitude", head_mag.blue_magnitude, mag_bus.blue_magnitude);
        compare_field("frame_end", head_mag.frame_end, mag_bus.frame_end);
      end
      mags_checked++;
      if (mag_bus.frame_end) frames_seen++;
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    pix_bus.valid = 1'b0;
    pix_bus.red   = '0;
    pix_bus.green = '0;
    pix_bus.blue  = '0;
    cfg_we        = 1'b0;
    cfg_idx       = REG_IMAGE_WIDTH;
    cfg_data      = '0;
    rst_ni        = 1'b0;
    pixels_sent   = 0;
    mags_checked  = 0;
    frames_seen   = 0;
    reg_writes    = 0;
    fail_count    = 0;
    cycle_count   = 0;
    src_quiet     = 1'b0;
    hold_requested = 1'b0;
    hold_served   = 1'b0;
    reset_predictor();
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows: clamped 3x3 frames back to back, extreme gradients, then a
    // register write in the middle of a frame to restart it.
    dir_rows[0]  = write_row(REG_IMAGE_WIDTH, 13'd0);
    dir_rows[1]  = write_row(REG_IMAGE_HEIGHT, 13'd2);
    // Red steps from 0 to 255 at the right column: full horizontal gradient.
    dir_rows[2]  = pixel_row(8'd0, 8'd0, 8'd255);
    dir_rows[3]  = pixel_row(8'd0, 8'd0, 8'd255);
    dir_rows[4]  = pixel_row(8'd255, 8'd0, 8'd255);
    dir_rows[5]  = pixel_row(8'd0, 8'd0, 8'd255);
    dir_rows[6]  = pixel_row(8'd0, 8'd0, 8'd255);
    dir_rows[7]  = pixel_row(8'd255, 8'd0, 8'd255);
    dir_rows[8]  = pixel_row(8'd0, 8'd0, 8'd255);
    dir_rows[9]  = pixel_row(8'd0, 8'd0, 8'd255);
    dir_rows[10] = checked_row(8'd255, 8'd0, 8'd255, '{8'd255, 8'd0, 8'd0, 1'b1});
    // Next frame: green steps at the bottom row, blue only at the ignored center.
    dir_rows[11] = pixel_row(8'd255, 8'd0, 8'd0);
    dir_rows[12] = pixel_row(8'd255, 8'd0, 8'd0);
    dir_rows[13] = pixel_row(8'd255, 8'd0, 8'd0);
    dir_rows[14] = pixel_row(8'd255, 8'd0, 8'd0);
    dir_rows[15] = pixel_row(8'd255, 8'd0, 8'd128);
    dir_rows[16] = pixel_row(8'd255, 8'd0, 8'd0);
    dir_rows[17] = pixel_row(8'd255, 8'd255, 8'd0);
    dir_rows[18] = pixel_row(8'd255, 8'd255, 8'd0);
    dir_rows[19] = checked_row(8'd255, 8'd255, 8'd0, '{8'd0, 8'd255, 8'd0, 1'b1});
    dir_rows[20] = pixel_row(8'd17, 8'd200, 8'd99);
    dir_rows[21] = pixel_row(8'd1, 8'd254, 8'd128);
    dir_rows[22] = write_row(REG_IMAGE_WIDTH, 13'd4);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_WRITE) write_reg(dir_rows[k].idx, dir_rows[k].data);
      else send_pixel(dir_rows[k].px, dir_rows[k].checked, dir_rows[k].want);
    end

    run_random_frames();

    // Widest row (clamped from the top of the register range): part of the first row,
    // where no result may appear.
    write_reg(REG_IMAGE_WIDTH, 13'd2047);
    write_reg(REG_IMAGE_HEIGHT, 13'd3);
    repeat (WIDE_PIXELS) send_pixel(random_pixel(TEX_NOISE, 8'd0), 1'b0, '0);
    // Tallest frame (clamped), narrow, fed for a few rows only.
    write_reg(REG_IMAGE_HEIGHT, 13'd8191);
    write_reg(REG_IMAGE_WIDTH, 13'd3);
    repeat (3 * 14) send_pixel(random_pixel(TEX_SMOOTH, 8'd100), 1'b0, '0);

    wait_for_results();
    repeat (END_CYCLES) @(posedge clk_i);

    $display("tb_top: run covered %0d pixels, %0d checked results, %0d frame ends,",
             pixels_sent, mags_checked, frames_seen);
    $display("tb_top: %0d register writes with clamped and in-range sizes", reg_writes);
    if (fail_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
